/* rtl/drss_pkg.sv */
// drss_pkg: shared types and constants of the deferred retry slot scheduler
// no dependencies; used by the channel interfaces and the top level

package drss_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned TRIES_W  = 4;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned EVENT_W  = 3;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned REG_W    = 2;
  localparam int unsigned CFG_W    = 16;

  // backoff is four times the send gap
  localparam int unsigned BACKOFF_SHIFT = 2;

  localparam logic [DELAY_W-1:0] RETRY_DELAY_RST = 16'd30;
  localparam logic [DELAY_W-1:0] SEND_GAP_RST    = 16'd5;
  localparam logic [TRIES_W-1:0] MAX_TRIES_RST   = 4'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_SERVICE = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NONE    = 2'd3
  } drss_kind_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_IDLE     = 3'd0,
    EV_SENT     = 3'd1,
    EV_RESCHED  = 3'd2,
    EV_LOST     = 3'd3,
    EV_QUEUED   = 3'd4,
    EV_DROPPED  = 3'd5,
    EV_GAP_WAIT = 3'd6
  } drss_event_e;

  typedef enum logic [REG_W-1:0] {
    REG_ENABLE      = 2'd0,
    REG_RETRY_DELAY = 2'd1,
    REG_SEND_GAP    = 2'd2,
    REG_MAX_TRIES   = 2'd3
  } drss_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_SCAN,
    ST_APPLY,
    ST_DONE
  } drss_state_e;

endpackage

/* rtl/drss_if.sv */
// drss channel interfaces: request items, result items and register writes
// depends on drss_pkg for field widths

interface drss_in_if;
  logic                           valid;
  logic                           ready;
  logic [drss_pkg::KIND_W-1:0]    kind;
  logic [drss_pkg::TIME_W-1:0]    now_ms;
  logic [drss_pkg::HANDLE_W-1:0]  frame_handle;
  logic                           tx_accepted;

  modport source (output valid, kind, now_ms, frame_handle, tx_accepted, input ready);
  modport sink (input valid, kind, now_ms, frame_handle, tx_accepted, output ready);
endinterface

interface drss_out_if;
  logic                           valid;
  logic                           ready;
  logic [drss_pkg::EVENT_W-1:0]   event_res;
  logic                           send_valid;
  logic [drss_pkg::HANDLE_W-1:0]  send_handle;
  logic [drss_pkg::SLOT_W-1:0]    slot_index;
  logic [drss_pkg::CNT_W-1:0]     retried_count;
  logic [drss_pkg::CNT_W-1:0]     lost_count;
  logic [drss_pkg::CNT_W-1:0]     dropped_count;

  modport source (output valid, event_res, send_valid, send_handle, slot_index,
                  retried_count, lost_count, dropped_count, input ready);
  modport sink (input valid, event_res, send_valid, send_handle, slot_index,
                retried_count, lost_count, dropped_count, output ready);
endinterface

interface drss_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [drss_pkg::REG_W-1:0]   reg_index;
  logic [drss_pkg::CFG_W-1:0]   wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

/* rtl/deferred_retry_slot_scheduler.sv */
// an enqueue scans one to SLOT_COUNT slots for a free one, then applies and reaches done;
// a service tick checks the send gap, scans one to SLOT_COUNT slots for a due one, then
// applies and reaches done; a gap wait goes from the gap check to done, and a disabled tick,
// clear and unused kinds go to apply and done. one item at a time, the scan taking one slot
// per cycle through the shared 32-bit time adder. reset clears slot valid bits, counters and
// last send time at once and loads register defaults; slot contents are not reset
// drss top level: slot store, scan sequencer, shared time adder, result register
// depends on drss_pkg and the drss channel interfaces

module deferred_retry_slot_scheduler #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  drss_cfg_if.sink   cfg_chan_i,
  drss_in_if.sink    in_chan_i,
  drss_out_if.source out_chan_o
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  drss_pkg::drss_state_e state_q, state_d;

  // latched item
  drss_pkg::drss_kind_e              kind_q;
  logic [drss_pkg::TIME_W-1:0]       now_q;
  logic [drss_pkg::HANDLE_W-1:0]     handle_q;
  logic                              acc_q;

  logic [IDX_W-1:0]                  idx_q;
  logic                              found_q;
  drss_pkg::drss_event_e             res_ev_q;
  logic                              res_sv_q;

  // slot store
  logic [SLOT_COUNT-1:0]             used_q;
  logic [drss_pkg::HANDLE_W-1:0]     slot_handle_q [SLOT_COUNT];
  logic [drss_pkg::TIME_W-1:0]       slot_due_q    [SLOT_COUNT];
  logic [drss_pkg::TRIES_W-1:0]      slot_tries_q  [SLOT_COUNT];

  logic [drss_pkg::TIME_W-1:0]       last_send_q;
  logic [drss_pkg::CNT_W-1:0]        sent_q, lost_q, dropped_q;

  // registers
  logic                              enable_q;
  logic [drss_pkg::DELAY_W-1:0]      retry_delay_q;
  logic [drss_pkg::DELAY_W-1:0]      send_gap_q;
  logic [drss_pkg::TRIES_W-1:0]      max_tries_q;

  // result register
  logic                              out_valid_q;
  drss_pkg::drss_event_e             out_ev_q;
  logic                              out_sv_q;
  logic [drss_pkg::HANDLE_W-1:0]     out_handle_q;
  logic [drss_pkg::SLOT_W-1:0]       out_slot_q;
  logic [drss_pkg::CNT_W-1:0]        out_sent_q, out_lost_q, out_dropped_q;

  logic                              in_acc, cfg_acc, out_free;
  logic [drss_pkg::TIME_W-1:0]       alu_b, alu_res;
  logic                              alu_sub;
  logic                              gap_wait, slot_hit, last_idx;
  logic [drss_pkg::TRIES_W-1:0]      tries_next;
  logic                              give_up;
  logic [31:0]                       idx_ext;
  logic                              show_slot;

  // apply-stage actions
  logic                              do_enq, do_drop, do_sent, do_resched, do_lost;
  logic                              do_clear, do_send;
  drss_pkg::drss_event_e             apply_ev;

  assign in_acc   = in_chan_i.valid && in_chan_i.ready;
  assign cfg_acc  = cfg_chan_i.valid && cfg_chan_i.ready;
  assign out_free = !out_valid_q || out_chan_o.ready;

  assign in_chan_i.ready  = (state_q == drss_pkg::ST_IDLE);
  assign cfg_chan_i.ready = 1'b1;

  // shared time adder
  always_comb begin
    alu_b   = last_send_q;
    alu_sub = 1'b1;
    unique case (state_q)
      drss_pkg::ST_SCAN: begin
        alu_b   = slot_due_q[idx_q];
        alu_sub = 1'b1;
      end
      drss_pkg::ST_APPLY: begin
        alu_sub = 1'b0;
        if (kind_q == drss_pkg::KIND_ENQUEUE) begin
          alu_b = drss_pkg::TIME_W'(retry_delay_q);
        end else begin
          alu_b = drss_pkg::TIME_W'({send_gap_q, {drss_pkg::BACKOFF_SHIFT{1'b0}}});
        end
      end
      default: begin
        alu_b   = last_send_q;
        alu_sub = 1'b1;
      end
    endcase
  end

  assign alu_res    = alu_sub ? (now_q - alu_b) : (now_q + alu_b);
  assign gap_wait   = alu_res < drss_pkg::TIME_W'(send_gap_q);
  assign slot_hit   = (kind_q == drss_pkg::KIND_ENQUEUE) ? !used_q[idx_q]
                                                         : (used_q[idx_q] && !alu_res[31]);
  assign last_idx   = (idx_q == IDX_W'(SLOT_COUNT - 1));
  assign tries_next = slot_tries_q[idx_q] + drss_pkg::TRIES_W'(1);
  assign give_up    = tries_next >= max_tries_q;
  assign idx_ext    = 32'(idx_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drss_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (drss_pkg::drss_kind_e'(in_chan_i.kind))
            drss_pkg::KIND_ENQUEUE: state_d = drss_pkg::ST_SCAN;
            drss_pkg::KIND_SERVICE: state_d = enable_q ? drss_pkg::ST_GAP
                                                       : drss_pkg::ST_APPLY;
            default:                state_d = drss_pkg::ST_APPLY;
          endcase
        end
      end
      drss_pkg::ST_GAP:   state_d = gap_wait ? drss_pkg::ST_DONE : drss_pkg::ST_SCAN;
      drss_pkg::ST_SCAN: begin
        if (slot_hit || last_idx) begin
          state_d = drss_pkg::ST_APPLY;
        end
      end
      drss_pkg::ST_APPLY: state_d = drss_pkg::ST_DONE;
      drss_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = drss_pkg::ST_IDLE;
        end
      end
      default:            state_d = drss_pkg::ST_IDLE;
    endcase
  end

  // apply decode
  always_comb begin
    do_enq     = 1'b0;
    do_drop    = 1'b0;
    do_sent    = 1'b0;
    do_resched = 1'b0;
    do_lost    = 1'b0;
    do_clear   = 1'b0;
    do_send    = 1'b0;
    apply_ev   = drss_pkg::EV_IDLE;
    if (state_q == drss_pkg::ST_APPLY) begin
      unique case (kind_q)
        drss_pkg::KIND_ENQUEUE: begin
          if (found_q) begin
            do_enq   = 1'b1;
            apply_ev = drss_pkg::EV_QUEUED;
          end else begin
            do_drop  = 1'b1;
            apply_ev = drss_pkg::EV_DROPPED;
          end
        end
        drss_pkg::KIND_SERVICE: begin
          if (found_q) begin
            do_send = 1'b1;
            priority if (acc_q) begin
              do_sent  = 1'b1;
              apply_ev = drss_pkg::EV_SENT;
            end else if (give_up) begin
              do_lost  = 1'b1;
              apply_ev = drss_pkg::EV_LOST;
            end else begin
              do_resched = 1'b1;
              apply_ev   = drss_pkg::EV_RESCHED;
            end
          end
        end
        drss_pkg::KIND_CLEAR: do_clear = 1'b1;
        default:              apply_ev = drss_pkg::EV_IDLE;
      endcase
    end
  end

  assign show_slot = (res_ev_q == drss_pkg::EV_SENT) || (res_ev_q == drss_pkg::EV_RESCHED) ||
                     (res_ev_q == drss_pkg::EV_LOST) || (res_ev_q == drss_pkg::EV_QUEUED);

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drss_pkg::ST_IDLE;
      used_q      <= '0;
      last_send_q <= '0;
      sent_q      <= '0;
      lost_q      <= '0;
      dropped_q   <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;

      if (in_acc) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (state_q == drss_pkg::ST_SCAN) begin
        found_q <= slot_hit;
        if (!slot_hit && !last_idx) begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end

      if (do_enq) begin
        used_q[idx_q] <= 1'b1;
      end
      if (do_sent || do_lost) begin
        used_q[idx_q] <= 1'b0;
      end
      if (do_send) begin
        last_send_q <= now_q;
      end
      if (do_sent) begin
        sent_q <= sent_q + drss_pkg::CNT_W'(1);
      end
      if (do_lost) begin
        lost_q <= lost_q + drss_pkg::CNT_W'(1);
      end
      if (do_drop) begin
        dropped_q <= dropped_q + drss_pkg::CNT_W'(1);
      end
      if (do_clear) begin
        used_q      <= '0;
        last_send_q <= '0;
        sent_q      <= '0;
        lost_q      <= '0;
        dropped_q   <= '0;
      end

      if (state_q == drss_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item latch, slot contents and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q   <= drss_pkg::drss_kind_e'(in_chan_i.kind);
      now_q    <= in_chan_i.now_ms;
      handle_q <= in_chan_i.frame_handle;
      acc_q    <= in_chan_i.tx_accepted;
      res_ev_q <= drss_pkg::EV_IDLE;
      res_sv_q <= 1'b0;
    end
    if (state_q == drss_pkg::ST_GAP && gap_wait) begin
      res_ev_q <= drss_pkg::EV_GAP_WAIT;
    end
    if (state_q == drss_pkg::ST_APPLY) begin
      res_ev_q <= apply_ev;
      res_sv_q <= do_send;
    end
    if (do_enq) begin
      slot_handle_q[idx_q] <= handle_q;
      slot_tries_q[idx_q]  <= '0;
      slot_due_q[idx_q]    <= alu_res;
    end
    if (do_send && !acc_q) begin
      slot_tries_q[idx_q] <= tries_next;
    end
    if (do_resched) begin
      slot_due_q[idx_q] <= alu_res;
    end
    if (state_q == drss_pkg::ST_DONE && out_free) begin
      out_ev_q      <= res_ev_q;
      out_sv_q      <= res_sv_q;
      out_handle_q  <= show_slot ? slot_handle_q[idx_q] : '0;
      out_slot_q    <= show_slot ? idx_ext[drss_pkg::SLOT_W-1:0] : '0;
      out_sent_q    <= sent_q;
      out_lost_q    <= lost_q;
      out_dropped_q <= dropped_q;
    end
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      retry_delay_q <= drss_pkg::RETRY_DELAY_RST;
      send_gap_q    <= drss_pkg::SEND_GAP_RST;
      max_tries_q   <= drss_pkg::MAX_TRIES_RST;
    end else if (cfg_acc) begin
      unique case (drss_pkg::drss_reg_e'(cfg_chan_i.reg_index))
        drss_pkg::REG_ENABLE:      enable_q      <= cfg_chan_i.wr_data[0];
        drss_pkg::REG_RETRY_DELAY: retry_delay_q <= cfg_chan_i.wr_data;
        drss_pkg::REG_SEND_GAP:    send_gap_q    <= cfg_chan_i.wr_data;
        drss_pkg::REG_MAX_TRIES:   max_tries_q   <= cfg_chan_i.wr_data[drss_pkg::TRIES_W-1:0];
        default:                   enable_q      <= enable_q;
      endcase
    end
  end

  assign out_chan_o.valid         = out_valid_q;
  assign out_chan_o.event_res     = out_ev_q;
  assign out_chan_o.send_valid    = out_sv_q;
  assign out_chan_o.send_handle   = out_handle_q;
  assign out_chan_o.slot_index    = out_slot_q;
  assign out_chan_o.retried_count = out_sent_q;
  assign out_chan_o.lost_count    = out_lost_q;
  assign out_chan_o.dropped_count = out_dropped_q;

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == drss_pkg::ST_DONE))
    else $error("result loaded outside done state");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == drss_pkg::ST_SCAN) |-> (idx_q <= IDX_W'(SLOT_COUNT - 1)))
    else $error("scan index past last slot");

  a_scan_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == drss_pkg::ST_SCAN) |->
      (kind_q == drss_pkg::KIND_ENQUEUE || kind_q == drss_pkg::KIND_SERVICE))
    else $error("slot scan for a kind that does not scan");

  a_lost_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lost_q != $past(lost_q)) |->
      (lost_q == $past(lost_q) + drss_pkg::CNT_W'(1) || lost_q == '0))
    else $error("lost counter moved by more than one");

  a_free_slot_on_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_enq |-> !used_q[idx_q])
    else $error("enqueue into a used slot");

endmodule

/* sim/deferred_retry_slot_scheduler_tb.sv */
// testbench for the deferred retry slot scheduler: directed and random request items,
// a scoreboard that predicts every result item and checks it field by field
// depends on drss_pkg, the drss channel interfaces and the scheduler top level
`timescale 1ns / 100ps

module deferred_retry_slot_scheduler_tb;

  localparam int unsigned SLOT_COUNT     = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned PHASE_COUNT    = 8;

  typedef struct packed {
    drss_pkg::drss_kind_e            kind;
    logic [drss_pkg::TIME_W-1:0]     now;
    logic [drss_pkg::HANDLE_W-1:0]   handle;
    logic                            tx_ok;
  } sched_req_t;

  typedef struct packed {
    drss_pkg::drss_event_e           ev;
    logic                            send_valid;
    logic [drss_pkg::HANDLE_W-1:0]   handle;
    logic [drss_pkg::SLOT_W-1:0]     slot;
    logic [drss_pkg::CNT_W-1:0]      retried;
    logic [drss_pkg::CNT_W-1:0]      lost;
    logic [drss_pkg::CNT_W-1:0]      dropped;
  } sched_res_t;

  class retry_slot_scoreboard;
    bit                            en = 1'b0;
    logic [drss_pkg::DELAY_W-1:0]  delay = drss_pkg::RETRY_DELAY_RST;
    logic [drss_pkg::DELAY_W-1:0]  gap = drss_pkg::SEND_GAP_RST;
    logic [drss_pkg::TRIES_W-1:0]  tries_limit = drss_pkg::MAX_TRIES_RST;
    bit                            used [SLOT_COUNT];
    logic [drss_pkg::HANDLE_W-1:0] hdl [SLOT_COUNT];
    logic [drss_pkg::TIME_W-1:0]   due [SLOT_COUNT];
    logic [drss_pkg::TRIES_W-1:0]  tries [SLOT_COUNT];
    logic [drss_pkg::TIME_W-1:0]   last_send = '0;
    logic [drss_pkg::CNT_W-1:0]    sent_total = '0;
    logic [drss_pkg::CNT_W-1:0]    lost_total = '0;
    logic [drss_pkg::CNT_W-1:0]    drop_total = '0;
    sched_res_t                    awaited_q [$];
    int unsigned                   errors = 0;
    int unsigned                   ev_seen [8];

    function void write_reg(drss_pkg::drss_reg_e idx, logic [drss_pkg::CFG_W-1:0] data);
      case (idx)
        drss_pkg::REG_ENABLE:      en = data[0];
        drss_pkg::REG_RETRY_DELAY: delay = data[drss_pkg::DELAY_W-1:0];
        drss_pkg::REG_SEND_GAP:    gap = data[drss_pkg::DELAY_W-1:0];
        drss_pkg::REG_MAX_TRIES:   tries_limit = data[drss_pkg::TRIES_W-1:0];
        default: ;
      endcase
    endfunction

    function int busy_slots();
      int n = 0;
      foreach (used[i]) n += used[i];
      return n;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    function void note_request(sched_req_t r);
      sched_res_t                   e;
      int                           s;
      logic [drss_pkg::TIME_W-1:0]  lag;
      logic [drss_pkg::TRIES_W-1:0] t;
      e = '0;
      e.ev = drss_pkg::EV_IDLE;
      s = -1;
      case (r.kind)
        drss_pkg::KIND_ENQUEUE: begin
          for (int i = SLOT_COUNT - 1; i >= 0; i--) if (!used[i]) s = i;
          if (s >= 0) begin
            hdl[s] = r.handle;
            tries[s] = '0;
            due[s] = r.now + drss_pkg::TIME_W'(delay);
            used[s] = 1'b1;
            e.ev = drss_pkg::EV_QUEUED;
            e.handle = r.handle;
            e.slot = drss_pkg::SLOT_W'(s);
          end else begin
            drop_total++;
            e.ev = drss_pkg::EV_DROPPED;
          end
        end
        drss_pkg::KIND_SERVICE: begin
          if (!en) begin
            e.ev = drss_pkg::EV_IDLE;
          end else if (r.now - last_send < drss_pkg::TIME_W'(gap)) begin
            e.ev = drss_pkg::EV_GAP_WAIT;
          end else begin
            // wrap-safe: due when now - due is not negative
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
              lag = r.now - due[i];
              if (used[i] && !lag[drss_pkg::TIME_W-1]) s = i;
            end
            if (s >= 0) begin
              last_send = r.now;
              e.send_valid = 1'b1;
              e.handle = hdl[s];
              e.slot = drss_pkg::SLOT_W'(s);
              if (r.tx_ok) begin
                sent_total++;
                used[s] = 1'b0;
                e.ev = drss_pkg::EV_SENT;
              end else begin
                t = tries[s] + 1'b1;
                tries[s] = t;
                if (t >= tries_limit) begin
                  lost_total++;
                  used[s] = 1'b0;
                  e.ev = drss_pkg::EV_LOST;
                end else begin
                  due[s] = r.now + (drss_pkg::TIME_W'(gap) << drss_pkg::BACKOFF_SHIFT);
                  e.ev = drss_pkg::EV_RESCHED;
                end
              end
            end
          end
        end
        drss_pkg::KIND_CLEAR: begin
          foreach (used[i]) used[i] = 1'b0;
          sent_total = '0;
          lost_total = '0;
          drop_total = '0;
          last_send = '0;
        end
        default: ;
      endcase
      e.retried = sent_total;
      e.lost = lost_total;
      e.dropped = drop_total;
      awaited_q.push_back(e);
    endfunction

    function void check_field(string field, logic [drss_pkg::CNT_W-1:0] want,
                              logic [drss_pkg::CNT_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(sched_res_t got);
      sched_res_t want;
      if (awaited_q.size() == 0) begin
        $error("result item with no request pending, event_res %0d", got.ev);
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      ev_seen[want.ev]++;
      check_field("event_res", drss_pkg::CNT_W'(want.ev), drss_pkg::CNT_W'(got.ev));
      check_field("send_valid", drss_pkg::CNT_W'(want.send_valid),
                  drss_pkg::CNT_W'(got.send_valid));
      check_field("send_handle", drss_pkg::CNT_W'(want.handle), drss_pkg::CNT_W'(got.handle));
      check_field("slot_index", drss_pkg::CNT_W'(want.slot), drss_pkg::CNT_W'(got.slot));
      check_field("retried_count", want.retried, got.retried);
      check_field("lost_count", want.lost, got.lost);
      check_field("dropped_count", want.dropped, got.dropped);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  drss_cfg_if cfg_if ();
  drss_in_if  in_if ();
  drss_out_if out_if ();

  deferred_retry_slot_scheduler #(
    .SLOT_COUNT(SLOT_COUNT)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_chan_i (cfg_if),
    .in_chan_i  (in_if),
    .out_chan_o (out_if)
  );

  retry_slot_scoreboard          sb;
  logic [drss_pkg::TIME_W-1:0]   clock_ms;
  bit                            in_idle_on;
  bit                            out_stall_on;
  int unsigned                   items_sent;
  int unsigned                   cfg_writes;
  int unsigned                   accept_pct;
  int unsigned                   quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  // result side back-pressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready = 1'b0;
      end else if (out_stall_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watch_results
    sched_res_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.ev = drss_pkg::drss_event_e'(out_if.event_res);
      got.send_valid = out_if.send_valid;
      got.handle = out_if.send_handle;
      got.slot = out_if.slot_index;
      got.retried = out_if.retried_count;
      got.lost = out_if.lost_count;
      got.dropped = out_if.dropped_count;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.pending());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_item(drss_pkg::drss_kind_e kind, logic [drss_pkg::TIME_W-1:0] now,
                           logic [drss_pkg::HANDLE_W-1:0] handle, logic tx_ok);
    sched_req_t r;
    @(negedge clk_i);
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_if.kind = kind;
    in_if.now_ms = now;
    in_if.frame_handle = handle;
    in_if.tx_accepted = tx_ok;
    in_if.valid = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    r = '{kind, now, handle, tx_ok};
    sb.note_request(r);
    if (kind != drss_pkg::KIND_NONE) items_sent++;
  endtask

  task automatic enqueue_frame(logic [drss_pkg::HANDLE_W-1:0] handle);
    push_item(drss_pkg::KIND_ENQUEUE, clock_ms, handle, 1'($urandom_range(0, 1)));
  endtask

  task automatic service_tick(logic tx_ok);
    push_item(drss_pkg::KIND_SERVICE, clock_ms, drss_pkg::HANDLE_W'($urandom), tx_ok);
  endtask

  task automatic write_reg(drss_pkg::drss_reg_e idx, logic [drss_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_if.reg_index = idx;
    cfg_if.wr_data = data;
    cfg_if.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [drss_pkg::CFG_W-1:0] en,
                                logic [drss_pkg::CFG_W-1:0] delay,
                                logic [drss_pkg::CFG_W-1:0] gap,
                                logic [drss_pkg::CFG_W-1:0] tries);
    settle();
    write_reg(drss_pkg::REG_ENABLE, en);
    write_reg(drss_pkg::REG_RETRY_DELAY, delay);
    write_reg(drss_pkg::REG_SEND_GAP, gap);
    write_reg(drss_pkg::REG_MAX_TRIES, tries);
  endtask

  task automatic run_phase(int unsigned budget);
    int unsigned stop;
    int unsigned step_max;
    int unsigned n;
    stop = items_sent + budget;
    step_max = 2 * sb.gap + sb.delay / 2 + 4;
    while (items_sent < stop) begin
      if ($urandom_range(0, 99) < 80) begin
        // fill some slots, then let time run until they drain or 40 steps pass
        n = $urandom_range(1, SLOT_COUNT + 2);
        repeat (n) begin
          enqueue_frame(drss_pkg::HANDLE_W'($urandom));
          clock_ms += $urandom_range(0, 3);
        end
        for (int k = 0; k < 40 && sb.busy_slots() > 0; k++) begin
          clock_ms += $urandom_range(0, step_max);
          if ($urandom_range(0, 9) == 0)
            enqueue_frame(drss_pkg::HANDLE_W'($urandom));
          else
            service_tick($urandom_range(0, 99) < accept_pct);
        end
      end else begin
        case ($urandom_range(0, 4))
          0: push_item(drss_pkg::KIND_NONE, $urandom, drss_pkg::HANDLE_W'($urandom),
                       1'($urandom_range(0, 1)));
          1: push_item(drss_pkg::KIND_CLEAR, clock_ms, drss_pkg::HANDLE_W'($urandom),
                       1'($urandom_range(0, 1)));
          default: begin
            if ($urandom_range(0, 1) == 0) clock_ms = $urandom;
            push_item(drss_pkg::drss_kind_e'($urandom_range(0, 1)), $urandom,
                      drss_pkg::HANDLE_W'($urandom), 1'($urandom_range(0, 1)));
          end
        endcase
      end
    end
  endtask

  initial begin
    sb = new;
    items_sent = 0;
    cfg_writes = 0;
    accept_pct = 50;
    in_idle_on = 1'b1;
    out_stall_on = 1'b1;
    clock_ms = '0;
    in_if.valid = 1'b0;
    in_if.kind = drss_pkg::KIND_NONE;
    in_if.now_ms = '0;
    in_if.frame_handle = '0;
    in_if.tx_accepted = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = drss_pkg::REG_ENABLE;
    cfg_if.wr_data = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, servicing disabled
    push_item(drss_pkg::KIND_SERVICE, 32'd100, 16'h0000, 1'b1);
    push_item(drss_pkg::KIND_ENQUEUE, 32'd100, 16'h0000, 1'b0);
    push_item(drss_pkg::KIND_ENQUEUE, 32'd200, 16'hFFFF, 1'b1);
    push_item(drss_pkg::KIND_NONE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    push_item(drss_pkg::KIND_CLEAR, 32'd300, 16'h0000, 1'b0);

    // zero delay and gap, one try, upper register bits set
    apply_settings(16'hFFFF, 16'd0, 16'd0, 16'hFFF1);
    push_item(drss_pkg::KIND_ENQUEUE, 32'hFFFF_FFFF, 16'h1234, 1'b0);
    push_item(drss_pkg::KIND_SERVICE, 32'h0000_0000, 16'h0000, 1'b1);
    push_item(drss_pkg::KIND_SERVICE, 32'h0000_0000, 16'h0000, 1'b1);
    repeat (SLOT_COUNT + 1)
      push_item(drss_pkg::KIND_ENQUEUE, 32'h8000_0000, drss_pkg::HANDLE_W'($urandom), 1'b0);
    push_item(drss_pkg::KIND_SERVICE, 32'h7FFF_FFFF, 16'h0000, 1'b1);
    push_item(drss_pkg::KIND_SERVICE, 32'h8000_0000, 16'h0000, 1'b0);

    // refusal with backoff, gap wait, then a send
    apply_settings(16'h0001, 16'd10, 16'd5, 16'd3);
    push_item(drss_pkg::KIND_SERVICE, 32'h8000_0010, 16'h0000, 1'b0);
    push_item(drss_pkg::KIND_SERVICE, 32'h8000_0012, 16'h0000, 1'b1);
    push_item(drss_pkg::KIND_SERVICE, 32'h8000_0015, 16'h0000, 1'b1);
    push_item(drss_pkg::KIND_CLEAR, 32'h8000_0016, 16'h0000, 1'b0);

    // try limit of zero loses on the first refusal
    apply_settings(16'h0001, 16'd10, 16'd5, 16'hFFF0);
    push_item(drss_pkg::KIND_ENQUEUE, 32'd50, 16'hA5A5, 1'b0);
    push_item(drss_pkg::KIND_SERVICE, 32'd60, 16'h0000, 1'b0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: apply_settings(16'h0001, 16'd30, 16'd5, 16'd3);
        1: apply_settings(16'h0001, 16'd0, 16'd0, 16'd1);
        2: apply_settings(16'h0001, 16'hFFFF, 16'hFFFF, 16'h000F);
        3: apply_settings(16'h0001, drss_pkg::CFG_W'($urandom_range(0, 200)),
                          drss_pkg::CFG_W'($urandom_range(0, 20)),
                          drss_pkg::CFG_W'($urandom_range(1, 15)));
        4: apply_settings(16'hFFFE, 16'd50, 16'd4, 16'd2);
        5: apply_settings(16'h0001, 16'd20, 16'd3, 16'hFFF0);
        6: apply_settings(drss_pkg::CFG_W'($urandom) | 16'h0001, drss_pkg::CFG_W'($urandom),
                          drss_pkg::CFG_W'($urandom), drss_pkg::CFG_W'($urandom));
        default: apply_settings(16'h0001, drss_pkg::CFG_W'($urandom_range(0, 100)),
                                drss_pkg::CFG_W'($urandom_range(0, 10)),
                                drss_pkg::CFG_W'($urandom_range(1, 4)));
      endcase
      in_idle_on = (p != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
      out_stall_on = (p != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
      accept_pct = $urandom_range(20, 90);
      clock_ms = $urandom;
      run_phase(p == 4 ? 60 : 175);
    end

    settle();
    $display("covered %0d request items and %0d register writes: %0d queued, %0d dropped",
             items_sent, cfg_writes, sb.ev_seen[drss_pkg::EV_QUEUED],
             sb.ev_seen[drss_pkg::EV_DROPPED]);
    $display("%0d sent, %0d rescheduled, %0d lost, %0d gap waits, %0d idle",
             sb.ev_seen[drss_pkg::EV_SENT], sb.ev_seen[drss_pkg::EV_RESCHED],
             sb.ev_seen[drss_pkg::EV_LOST], sb.ev_seen[drss_pkg::EV_GAP_WAIT],
             sb.ev_seen[drss_pkg::EV_IDLE]);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
